// ===== design/keyed_parent_table_macros.svh =====
// ----------------------------------------------------------------------------
// keyed_parent_table assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_PARENT_TABLE_MACROS_SVH
`define KEYED_PARENT_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop at every clock edge outside reset
`define KPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop at every clock edge, reset included
`define KPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/kpt_pkg.sv =====
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared constants, codes and control types of the keyed parent table.
// ----------------------------------------------------------------------------
package kpt_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int RESULT_MAX    = 32;

    localparam int KEY_BITS    = 32;
    localparam int INFO_BITS   = 32;
    localparam int LIMIT_BITS  = 6;
    localparam int STATUS_BITS = 3;
    localparam int REQ_BITS    = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd32;

    localparam logic [REQ_BITS-1:0] REQ_INSERT        = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_DELETE        = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_SEARCH_KEY    = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_SEARCH_PARENT = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOPAR    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture a new item, rewind the scan
        logic restart;    // rewind the scan for the compaction pass
        logic run;        // advance the scan
        logic del_pass;   // scan rewrites entries (delete compaction)
        logic emit_final; // issue the closing result, commit the table
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_end;   // every entry read and evaluated
        logic del_hit;    // delete found its key
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// ===== design/kpt_req_if.sv =====
// ----------------------------------------------------------------------------
// kpt_req_if
// Request channel: valid/ready handshake with the request item.
// ----------------------------------------------------------------------------
interface kpt_req_if;
    logic                          valid;
    logic                          ready;
    logic [kpt_pkg::REQ_BITS-1:0]  req_type;
    logic [kpt_pkg::KEY_BITS-1:0]  key;
    logic [kpt_pkg::KEY_BITS-1:0]  parent_key;
    logic [kpt_pkg::INFO_BITS-1:0] info;

    modport source (output valid, req_type, key, parent_key, info, input ready);
    modport sink   (input valid, req_type, key, parent_key, info, output ready);
endinterface

// ===== design/kpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kpt_rsp_if
// Result channel: valid/ready handshake with the result item.
// ----------------------------------------------------------------------------
interface kpt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [kpt_pkg::STATUS_BITS-1:0] status;
    logic [kpt_pkg::KEY_BITS-1:0]    out_key;
    logic [kpt_pkg::KEY_BITS-1:0]    out_parent;
    logic [kpt_pkg::INFO_BITS-1:0]   out_info;
    logic                            last;

    modport source (output valid, status, out_key, out_parent, out_info, last,
                    input ready);
    modport sink   (input valid, status, out_key, out_parent, out_info, last,
                    output ready);
endinterface

// ===== design/keyed_parent_table.sv =====
// ----------------------------------------------------------------------------
// keyed_parent_table
// Insertion-ordered keyed table with parent links, insert/delete/search.
// ----------------------------------------------------------------------------
// One request item is taken at a time; the request port is ready only while
// the sequencer is idle, but a finished result may still sit in the output
// register. Every request reads the stored entries one per cycle through the
// single read port of the entry memories, unless the scan is stalled. Insert,
// both searches and a delete that misses make one scan pass; a delete that hits
// runs a second, compaction pass over the memory. The closing result waits
// until the output register is free. A parent search also holds its scan
// whenever a further match arrives while the previous one cannot yet leave the
// output register. The memories need no clearing after reset: only slots below
// the entry count are ever read.
// ----------------------------------------------------------------------------
`include "keyed_parent_table_macros.svh"

module keyed_parent_table #(
    parameter int CAPACITY  = kpt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = kpt_pkg::KEY_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kpt_pkg::LIMIT_BITS-1:0] i_cfg_data,
    kpt_req_if.sink                        i_req,
    kpt_rsp_if.source                      o_rsp
);
    import kpt_pkg::*;

    logic [LIMIT_BITS-1:0] r_entry_limit;
    t_cmd                  cmd;
    t_sts                  sts;
    logic                  req_ready;

    // entry limit register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_entry_limit <= i_cfg_data;
        end
    end

    assign i_req.ready = req_ready;

    kpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (req_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kpt_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_entry_limit (r_entry_limit),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .i_parent_key  (i_req.parent_key),
        .i_info        (i_req.info),
        .o_rsp         (o_rsp)
    );

    // the closing result may only be issued into a free output register
    `KPT_ASSERT(a_final_free, i_clk, i_rst_n, cmd.emit_final |-> sts.out_free, "final result into busy output")
    // an accepted item keeps the request port closed the next cycle
    `KPT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready, "ready after accept")
    // the compaction pass starts only for a delete that found its key
    `KPT_ASSERT(a_restart_hit, i_clk, i_rst_n, cmd.restart |-> (sts.del_hit && sts.scan_end), "compaction without hit")
    // load and the closing result never coincide
    `KPT_ASSERT_ALWAYS(a_load_final, i_clk, !(cmd.load && cmd.emit_final), "load with final result")

endmodule

// ===== design/kpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpt_ctrl
// Sequencer: scan pass, optional compaction pass, closing result.
// ----------------------------------------------------------------------------
module kpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kpt_pkg::t_sts i_sts,
    output kpt_pkg::t_cmd o_cmd
);
    import kpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.run = 1'b1;
                if (i_sts.scan_end) begin
                    if (i_sts.del_hit) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_DEL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DEL: begin
                o_cmd.run      = 1'b1;
                o_cmd.del_pass = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/kpt_dpath.sv =====
// ----------------------------------------------------------------------------
// kpt_dpath
// Entry memories, scan pipeline, match logic and the output register.
// ----------------------------------------------------------------------------
module kpt_dpath #(
    parameter int CAPACITY  = kpt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = kpt_pkg::KEY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kpt_pkg::t_cmd                   i_cmd,
    output kpt_pkg::t_sts                   o_sts,
    input  logic [kpt_pkg::LIMIT_BITS-1:0]  i_entry_limit,
    input  logic [kpt_pkg::REQ_BITS-1:0]    i_req_type,
    input  logic [kpt_pkg::KEY_BITS-1:0]    i_key,
    input  logic [kpt_pkg::KEY_BITS-1:0]    i_parent_key,
    input  logic [kpt_pkg::INFO_BITS-1:0]   i_info,
    kpt_rsp_if.source                       o_rsp
);
    import kpt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int MW = $clog2(RESULT_MAX + 1);
    localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

    logic [KW-1:0]        mem_key  [CAPACITY];
    logic [KW-1:0]        mem_par  [CAPACITY];
    logic [INFO_BITS-1:0] mem_info [CAPACITY];

    logic [REQ_BITS-1:0]    r_req;
    logic [KW-1:0]          r_key;
    logic [KW-1:0]          r_par;
    logic [INFO_BITS-1:0]   r_info;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_ptr;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic [KW-1:0]          r_rd_key;
    logic [KW-1:0]          r_rd_par;
    logic [INFO_BITS-1:0]   r_rd_info;
    logic                   r_hit;
    logic [AW-1:0]          r_pos;
    logic                   r_par_seen;
    logic                   r_pend_vld;
    logic [KW-1:0]          r_pend_key;
    logic [KW-1:0]          r_pend_par;
    logic [INFO_BITS-1:0]   r_pend_info;
    logic [MW-1:0]          r_nmatch;

    logic                   r_o_vld;
    logic [STATUS_BITS-1:0] r_o_status;
    logic [KEY_BITS-1:0]    r_o_key;
    logic [KEY_BITS-1:0]    r_o_par;
    logic [INFO_BITS-1:0]   r_o_info;
    logic                   r_o_last;

    logic                   out_free;
    logic                   key_zero;
    logic                   key_eq;
    logic                   take;
    logic                   stall;
    logic                   adv;
    logic                   eval;
    logic                   issue;
    logic                   push_mid;
    logic                   full;
    logic [STATUS_BITS-1:0] fin_status;
    logic                   fin_entry;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [KW-1:0]          wr_key;
    logic [KW-1:0]          wr_par;
    logic [INFO_BITS-1:0]   wr_info;
    logic                   ins_wr;

    assign out_free = !r_o_vld || o_rsp.ready;
    assign key_zero = (r_key == '0);
    assign key_eq   = (r_rd_key == r_key);
    assign take     = (r_req == REQ_SEARCH_PARENT) && (r_rd_par == r_par)
                      && (r_nmatch < MW'(RESULT_MAX));
    // hold the scan while a new match arrives and the held match cannot leave
    assign stall    = r_rd_vld && take && r_pend_vld && !out_free && !i_cmd.del_pass;
    assign adv      = i_cmd.run && !stall;
    assign eval     = adv && r_rd_vld;
    assign issue    = adv && (r_ptr != r_count);
    assign push_mid = eval && !i_cmd.del_pass && take && r_pend_vld;
    assign full     = (LW'(r_count) >= LW'(i_entry_limit)) || (r_count == CW'(CAPACITY));

    always_comb begin
        fin_status = ST_OK;
        fin_entry  = 1'b0;
        unique case (r_req)
            REQ_INSERT: begin
                priority if (key_zero)                  fin_status = ST_ZERO;
                else if (full)                          fin_status = ST_FULL;
                else if (r_hit)                         fin_status = ST_DUP;
                else if (r_par != '0 && !r_par_seen)    fin_status = ST_NOPAR;
                else                                    fin_status = ST_OK;
            end
            REQ_DELETE: begin
                fin_status = (key_zero || !r_hit) ? ST_NOTFOUND : ST_OK;
            end
            REQ_SEARCH_KEY: begin
                fin_status = (key_zero || !r_hit) ? ST_NOTFOUND : ST_OK;
                fin_entry  = !key_zero && r_hit;
            end
            REQ_SEARCH_PARENT: begin
                fin_status = r_pend_vld ? ST_OK : ST_NOTFOUND;
                fin_entry  = r_pend_vld;
            end
            default: fin_status = ST_NOTFOUND;
        endcase
    end

    assign ins_wr = i_cmd.emit_final && (r_req == REQ_INSERT) && (fin_status == ST_OK);

    // memory write: insert appends; compaction rewrites below the deleted slot, shifts down above it
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_key  = r_rd_key;
        wr_par  = (r_rd_par == r_key) ? '0 : r_rd_par;
        wr_info = r_rd_info;
        if (ins_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_key  = r_key;
            wr_par  = r_par;
            wr_info = r_info;
        end else if (eval && i_cmd.del_pass && (r_rd_idx != r_pos)) begin
            wr_en   = 1'b1;
            wr_addr = (r_rd_idx > r_pos) ? r_rd_idx - AW'(1) : r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr]  <= wr_key;
            mem_par[wr_addr]  <= wr_par;
            mem_info[wr_addr] <= wr_info;
        end
        if (issue && !i_cmd.load && !i_cmd.restart) begin
            r_rd_key  <= mem_key[r_ptr[AW-1:0]];
            r_rd_par  <= mem_par[r_ptr[AW-1:0]];
            r_rd_info <= mem_info[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ptr      <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_par_seen <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nmatch   <= '0;
        end else if (i_cmd.load) begin
            r_req      <= i_req_type;
            r_key      <= i_key[KW-1:0];
            r_par      <= i_parent_key[KW-1:0];
            r_info     <= i_info;
            r_ptr      <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_par_seen <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nmatch   <= '0;
        end else if (i_cmd.restart) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_ptr    <= r_ptr + CW'(1);
                    r_rd_idx <= r_ptr[AW-1:0];
                end
            end
            if (eval && !i_cmd.del_pass) begin
                if (key_eq && !r_hit) begin
                    r_hit <= 1'b1;
                    r_pos <= r_rd_idx;
                    if (r_req == REQ_SEARCH_KEY) begin
                        r_pend_key  <= r_rd_key;
                        r_pend_par  <= r_rd_par;
                        r_pend_info <= r_rd_info;
                    end
                end
                if (r_rd_key == r_par) begin
                    r_par_seen <= 1'b1;
                end
                if (take) begin
                    r_pend_vld  <= 1'b1;
                    r_pend_key  <= r_rd_key;
                    r_pend_par  <= r_rd_par;
                    r_pend_info <= r_rd_info;
                    r_nmatch    <= r_nmatch + MW'(1);
                end
            end
            if (ins_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.emit_final && (r_req == REQ_DELETE)
                         && (fin_status == ST_OK)) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (push_mid) begin
            r_o_vld    <= 1'b1;
            r_o_status <= ST_OK;
            r_o_key    <= KEY_BITS'(r_pend_key);
            r_o_par    <= KEY_BITS'(r_pend_par);
            r_o_info   <= r_pend_info;
            r_o_last   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_o_vld    <= 1'b1;
            r_o_status <= fin_status;
            r_o_key    <= fin_entry ? KEY_BITS'(r_pend_key) : '0;
            r_o_par    <= fin_entry ? KEY_BITS'(r_pend_par) : '0;
            r_o_info   <= fin_entry ? r_pend_info : '0;
            r_o_last   <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_rsp.valid      = r_o_vld;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.out_key    = r_o_key;
    assign o_rsp.out_parent = r_o_par;
    assign o_rsp.out_info   = r_o_info;
    assign o_rsp.last       = r_o_last;

    assign o_sts.scan_end = (r_ptr == r_count) && !r_rd_vld;
    assign o_sts.del_hit  = (r_req == REQ_DELETE) && r_hit && !key_zero;
    assign o_sts.out_free = out_free;

endmodule
